FILE: rtl/ifmt_pkg.sv
package ifmt_pkg;

    localparam int IFMT_MAX_WIDTH = 60;
    localparam int DIGITS_MAX     = 11;
    localparam int DIG_IDX_W      = $clog2(DIGITS_MAX);

    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef enum logic [1:0] {
        KIND_SDEC = 2'd0,
        KIND_UDEC = 2'd1,
        KIND_HEX  = 2'd2,
        KIND_PTR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic setup;
        logic emit;
    } ifmt_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic count_zero;
        logic emit_last;
        logic out_free;
    } ifmt_sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = CH_UPPER + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

FILE: rtl/ifmt_ctrl.sv
module ifmt_ctrl
    import ifmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ifmt_sts_t sts,
    output ifmt_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = sts.count_zero ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/ifmt_dp.sv
module ifmt_dp
    import ifmt_pkg::*;
#(
    parameter int MAX_WIDTH = IFMT_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ifmt_cmd_t   cmd,
    output ifmt_sts_t   sts,
    input  logic [1:0]  in_kind,
    input  logic [31:0] in_value,
    input  logic        in_left,
    input  logic        in_zpad,
    input  logic [5:0]  in_width,
    input  logic [11:0] in_space,
    output logic [7:0]  char_out,
    output logic        last,
    output logic        out_valid,
    input  logic        out_ready
);

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WIDTH);

    logic [1:0]           kind_reg;
    logic                 left_reg;
    logic [7:0]           padc_reg;
    logic [CNT_W-1:0]     width_reg;
    logic [11:0]          space_reg;
    logic [31:0]          mag_reg;
    logic [3:0]           dig_reg [DIGITS_MAX];
    logic [3:0]           ndig_reg;
    logic [1:0]           pre_reg;
    logic [3:0]           len_reg;
    logic [CNT_W-1:0]     pad_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [3:0]           tpos_reg;
    logic [DIG_IDX_W-1:0] ridx_reg;
    logic                 valid_reg;
    logic [7:0]           char_reg;
    logic                 last_reg;

    logic                 neg;
    logic [CNT_W-1:0]     width_clamp;
    logic [63:0]          prod;
    logic [31:0]          quot;
    logic [31:0]          mag_next;
    logic [3:0]           digit;
    logic [3:0]           ten_q_lo;
    logic [3:0]           len_next;
    logic [CNT_W-1:0]     len_ext;
    logic [CNT_W-1:0]     pad_next;
    logic [CNT_W-1:0]     total;
    logic [11:0]          cmin;
    logic [11:0]          cclamp;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     len_cnt;
    logic                 is_text;
    logic                 in_prefix;
    logic [7:0]           text_char;
    logic [7:0]           emit_char;
    logic [CNT_W:0]       k_inc;

    assign neg         = (kind_t'(in_kind) == KIND_SDEC) && in_value[31];
    assign width_clamp = ({1'b0, in_width} > 7'(MAX_WIDTH)) ? MAXW : CNT_W'(in_width);

    assign prod     = {32'd0, mag_reg} * {32'd0, RECIP_10};
    assign quot     = {3'd0, prod[63:RECIP_SHIFT]};
    assign ten_q_lo = {quot[0], 3'd0} + {quot[2:0], 1'b0};

    always_comb
    begin
        if (kind_reg == KIND_HEX || kind_reg == KIND_PTR)
        begin
            digit    = mag_reg[3:0];
            mag_next = {4'd0, mag_reg[31:4]};
        end
        else
        begin
            digit    = mag_reg[3:0] - ten_q_lo;
            mag_next = quot;
        end
    end

    assign len_next   = ndig_reg + {2'd0, pre_reg};
    assign len_ext    = CNT_W'(len_next);
    assign pad_next   = (width_reg > len_ext) ? (width_reg - len_ext) : '0;
    assign total      = len_ext + pad_next;
    assign cmin       = (12'(total) < space_reg) ? 12'(total) : space_reg;
    assign cclamp     = (cmin > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : cmin;
    assign count_next = cclamp[CNT_W-1:0];

    assign len_cnt   = CNT_W'(len_reg);
    assign is_text   = left_reg ? (k_reg < len_cnt) : (k_reg >= pad_reg);
    assign in_prefix = tpos_reg < {2'd0, pre_reg};

    always_comb
    begin
        if (in_prefix)
        begin
            if (kind_reg == KIND_PTR)
            begin
                text_char = (tpos_reg == 4'd0) ? CH_ZERO : CH_X;
            end
            else
            begin
                text_char = CH_MINUS;
            end
        end
        else
        begin
            text_char = digit_char(dig_reg[ridx_reg]);
        end
    end

    assign emit_char = is_text ? text_char : padc_reg;
    assign k_inc     = {1'b0, k_reg} + (CNT_W + 1)'(1);

    assign sts.conv_done  = (mag_next == 32'd0);
    assign sts.count_zero = (count_next == '0);
    assign sts.emit_last  = (k_inc == {1'b0, count_reg});
    assign sts.out_free   = !valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            left_reg  <= in_left;
            padc_reg  <= (in_zpad && !in_left) ? CH_ZERO : CH_SPACE;
            width_reg <= width_clamp;
            space_reg <= in_space;
            mag_reg   <= neg ? (32'd0 - in_value) : in_value;
            ndig_reg  <= 4'd0;
            pre_reg   <= neg ? 2'd1 : ((kind_t'(in_kind) == KIND_PTR) ? 2'd2 : 2'd0);
        end
        if (cmd.step)
        begin
            dig_reg[ndig_reg[DIG_IDX_W-1:0]] <= digit;
            ndig_reg <= ndig_reg + 4'd1;
            mag_reg  <= mag_next;
        end
        if (cmd.setup)
        begin
            len_reg   <= len_next;
            pad_reg   <= pad_next;
            count_reg <= count_next;
            k_reg     <= '0;
            tpos_reg  <= 4'd0;
            ridx_reg  <= DIG_IDX_W'(ndig_reg - 4'd1);
        end
        if (cmd.emit)
        begin
            k_reg    <= k_inc[CNT_W-1:0];
            char_reg <= emit_char;
            last_reg <= sts.emit_last;
            if (is_text)
            begin
                tpos_reg <= tpos_reg + 4'd1;
                if (!in_prefix)
                begin
                    ridx_reg <= ridx_reg - DIG_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign char_out  = char_reg;
    assign last      = last_reg;
    assign out_valid = valid_reg;

endmodule

FILE: rtl/integer_field_formatter.sv
// The digit loop handles one multiply by the reciprocal of ten or one hex nibble per cycle,
// and the single output register takes one character per cycle while m_tready allows it.
// A new item is accepted only in idle, after the last character of the previous item has
// been loaded into the output register, or after setup finds an empty field.
// Reset: asynchronous, active low; the controller returns to idle and the output empties.
module integer_field_formatter
    import ifmt_pkg::*;
#(
    parameter int MAX_WIDTH = IFMT_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // value, left_adjust, zero_pad, field_width, space_left
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // char_out
    output logic        m_tlast
);

    ifmt_cmd_t cmd;
    ifmt_sts_t sts;

    ifmt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ifmt_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_kind   (s_tuser),
        .in_value  (s_tdata[31:0]),
        .in_left   (s_tdata[32]),
        .in_zpad   (s_tdata[33]),
        .in_width  (s_tdata[39:34]),
        .in_space  (s_tdata[51:40]),
        .char_out  (m_tdata),
        .last      (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule
